// ===== hdl/rsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfp_pkg: shared types and constants for the radix string converter
// Character codes, field widths, parser states and the radix clamp.
// ----------------------------------------------------------------------------
package rsfp_pkg;

  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned RADIX_W       = 5;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned INT_BITS_DEF  = 32;
  localparam int unsigned FRAC_BITS_DEF = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;

  // Letter digits sit at code low nibble 1..6, value 10..15
  localparam logic [DIGIT_W-1:0] LETTER_OFS = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_DIV,
    ST_SUM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               is_digit;
    logic               is_minus;
    logic               is_point;
    logic [DIGIT_W-1:0] digit;
  } chr_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

endpackage

// ===== hdl/rsfp_if.sv =====
// ----------------------------------------------------------------------------
// rsfp_if: channel interfaces for the radix string converter
// Character input, result output and radix write channels.
// ----------------------------------------------------------------------------
interface rsfp_in_if;
  import rsfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface rsfp_out_if;
  import rsfp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

interface rsfp_cfg_if;
  import rsfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

// ===== hdl/rsfp_dec.sv =====
// ----------------------------------------------------------------------------
// rsfp_dec: character classifier
// Sorts one ASCII code into digit, minus, point or other, with digit value.
// ----------------------------------------------------------------------------
module rsfp_dec (
  input  logic [rsfp_pkg::CHAR_W-1:0] char_i,
  output rsfp_pkg::chr_t              chr_o
);
  import rsfp_pkg::*;

  always_comb begin
    chr_o = '0;
    case (char_i) inside
      [CH_0:CH_9]: begin
        chr_o.is_digit = 1'b1;
        chr_o.digit    = char_i[DIGIT_W-1:0];
      end
      [CH_UA:CH_UF], [CH_LA:CH_LF]: begin
        chr_o.is_digit = 1'b1;
        chr_o.digit    = char_i[DIGIT_W-1:0] + LETTER_OFS;
      end
      CH_MINUS: begin
        chr_o.is_minus = 1'b1;
      end
      CH_POINT: begin
        chr_o.is_point = 1'b1;
      end
      default: begin
        chr_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/rsfp_div.sv =====
// ----------------------------------------------------------------------------
// rsfp_div: bit-serial restoring divider
// Divides a WIDTH-bit dividend by the radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsfp_div #(
  parameter int unsigned WIDTH = rsfp_pkg::FRAC_BITS_DEF + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [WIDTH-1:0]             dividend_i,
  input  logic [rsfp_pkg::RADIX_W-1:0] divisor_i,
  output logic [WIDTH-1:0]             quot_o,
  output logic                         done_o
);
  import rsfp_pkg::*;

  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [WIDTH-1:0]     dq_q;
  logic [RADIX_W-1:0]   rem_q;
  logic [RADIX_W:0]     shifted;
  logic                 qbit;
  logic [RADIX_W-1:0]   rem_d;
  logic                 last_step;

  // Remainder stays below the divisor, so one extra bit holds the shifted value
  always_comb begin
    shifted   = {rem_q, dq_q[WIDTH-1]};
    qbit      = (shifted >= {1'b0, divisor_i});
    rem_d     = qbit ? RADIX_W'(shifted - {1'b0, divisor_i}) : shifted[RADIX_W-1:0];
    last_step = busy_q && (cnt_q == CNT_LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (last_step) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[WIDTH-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign quot_o = dq_q;
  assign done_o = done_q;

endmodule

// ===== hdl/rsfp_fmt.sv =====
// ----------------------------------------------------------------------------
// rsfp_fmt: result formatter
// Applies sign and saturation, then sign-extends the fixed-point word.
// ----------------------------------------------------------------------------
module rsfp_fmt #(
  parameter int unsigned INT_BITS  = rsfp_pkg::INT_BITS_DEF,
  parameter int unsigned FRAC_BITS = rsfp_pkg::FRAC_BITS_DEF
) (
  input  logic [INT_BITS:0]                   int_total_i,
  input  logic [FRAC_BITS-1:0]                frac_low_i,
  input  logic                                neg_i,
  input  logic                                ovf_i,
  output logic signed [rsfp_pkg::VALUE_W-1:0] value_o,
  output logic                                ovf_o
);
  import rsfp_pkg::*;

  localparam int unsigned W = INT_BITS + FRAC_BITS;
  localparam logic [INT_BITS:0] HALF  = (INT_BITS + 1)'(1) << (INT_BITS - 1);
  localparam logic [W-1:0]      W_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]      W_MIN = {1'b1, {(W - 1){1'b0}}};

  logic         pos_sat;
  logic         neg_sat;
  logic [W-1:0] mag;
  logic [W-1:0] res_w;

  always_comb begin
    pos_sat = ovf_i || (int_total_i >= HALF);
    neg_sat = ovf_i || (int_total_i > HALF) || ((int_total_i == HALF) && (|frac_low_i));
    mag     = {int_total_i[INT_BITS-1:0], frac_low_i};
    if (neg_i) begin
      res_w = neg_sat ? W_MIN : (~mag + 1'b1);
      ovf_o = neg_sat;
    end else begin
      res_w = pos_sat ? W_MAX : mag;
      ovf_o = pos_sat;
    end
    value_o = VALUE_W'(signed'(res_w));
  end

endmodule

// ===== hdl/radix_string_to_fixed_point.sv =====
// Plain characters pass through the parse state before the next ready.
// The first character of a string and each fraction digit also wait in the divide
// state for the bit-serial divider, which yields one quotient bit a cycle.
// A last character passes the sum and emit states before its result is offered.
// Reset: radix 10, parser at string start, output empty; no clearing pass.
// ----------------------------------------------------------------------------
// radix_string_to_fixed_point: ASCII radix string to signed fixed point
// Parses one character per transaction and emits a Q format result at the end.
// ----------------------------------------------------------------------------
module radix_string_to_fixed_point #(
  parameter int unsigned INT_BITS  = rsfp_pkg::INT_BITS_DEF,
  parameter int unsigned FRAC_BITS = rsfp_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rsfp_cfg_if.sink          cfg_i,
  rsfp_in_if.sink           in_i,
  rsfp_out_if.source        out_o
);
  import rsfp_pkg::*;

  localparam int unsigned FAW = FRAC_BITS + DIGIT_W;
  localparam int unsigned PW  = INT_BITS + RADIX_W;
  localparam int unsigned DW  = FRAC_BITS + 1;
  localparam logic [FRAC_BITS-1:0] WEIGHT_RST =
    FRAC_BITS'((64'd1 << FRAC_BITS) / 64'(RADIX_RESET));

  state_e state_q, state_d;

  logic [RADIX_W-1:0]  radix_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;
  logic [INT_BITS-1:0] int_acc_q;
  logic [FAW-1:0]      frac_acc_q;
  logic [FRAC_BITS-1:0] weight_q;
  logic                neg_q;
  logic                in_frac_q;
  logic                first_q;
  logic                ovf_q;
  logic [INT_BITS:0]   int_total_q;
  logic                out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                out_ovf_q;

  chr_t                chr;
  logic [RADIX_W-1:0]  radix_eff;
  logic                minus_lead;
  logic                take_point;
  logic                take_int;
  logic                take_frac;
  logic                div_go;
  logic [DW-1:0]       div_dividend;
  logic [DW-1:0]       quot;
  logic                div_done;
  logic [PW-1:0]       horner;
  logic                int_ovf;
  logic [FAW-1:0]      frac_sum;
  logic [INT_BITS:0]   int_total_d;
  logic                slot_free;
  logic signed [VALUE_W-1:0] fmt_value;
  logic                fmt_ovf;

  logic                in_ready;
  logic                parse_en;
  logic                load_w;
  logic                sum_en;
  logic                emit_en;

  rsfp_dec u_dec (
    .char_i (char_q),
    .chr_o  (chr)
  );

  rsfp_div #(
    .WIDTH (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (parse_en & div_go),
    .dividend_i (div_dividend),
    .divisor_i  (radix_eff),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  rsfp_fmt #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_fmt (
    .int_total_i (int_total_q),
    .frac_low_i  (frac_acc_q[FRAC_BITS-1:0]),
    .neg_i       (neg_q),
    .ovf_i       (ovf_q),
    .value_o     (fmt_value),
    .ovf_o       (fmt_ovf)
  );

  always_comb begin
    radix_eff    = eff_radix(radix_q);
    minus_lead   = first_q & chr.is_minus;
    take_point   = !minus_lead & !in_frac_q & chr.is_point;
    take_int     = !minus_lead & chr.is_digit & !in_frac_q;
    take_frac    = !minus_lead & chr.is_digit & in_frac_q;
    // First character loads the weight; fraction digits shrink it
    div_go       = first_q | take_frac;
    div_dividend = first_q ? (DW'(1) << FRAC_BITS) : DW'(weight_q);
    horner       = PW'(int_acc_q) * PW'(radix_eff) + PW'(chr.digit);
    int_ovf      = |horner[PW-1:INT_BITS];
    frac_sum     = frac_acc_q + FAW'(chr.digit) * FAW'(weight_q);
    int_total_d  = (INT_BITS + 1)'(int_acc_q) + (INT_BITS + 1)'(frac_acc_q[FAW-1:FRAC_BITS]);
    slot_free    = !out_valid_q | out_o.ready;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_PARSE;
      end
      ST_PARSE: begin
        if (div_go)      state_d = ST_DIV;
        else if (last_q) state_d = ST_SUM;
        else             state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) state_d = last_q ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    parse_en = 1'b0;
    load_w   = 1'b0;
    sum_en   = 1'b0;
    emit_en  = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_PARSE: parse_en = 1'b1;
      ST_DIV:   load_w   = div_done;
      ST_SUM:   sum_en   = 1'b1;
      ST_EMIT:  emit_en  = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      out_valid_q <= 1'b0;
      first_q     <= 1'b1;
      neg_q       <= 1'b0;
      in_frac_q   <= 1'b0;
      ovf_q       <= 1'b0;
      int_acc_q   <= '0;
      frac_acc_q  <= '0;
      weight_q    <= WEIGHT_RST;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) radix_q <= cfg_i.radix;
      if (parse_en) begin
        first_q <= 1'b0;
        if (minus_lead) neg_q     <= 1'b1;
        if (take_point) in_frac_q <= 1'b1;
        if (take_int) begin
          int_acc_q <= int_ovf ? '1 : horner[INT_BITS-1:0];
          ovf_q     <= ovf_q | int_ovf;
        end
        if (take_frac) frac_acc_q <= frac_sum;
      end
      if (load_w) weight_q <= quot[FRAC_BITS-1:0];
      // Drop the string state once its result is handed over
      if (emit_en) begin
        first_q    <= 1'b1;
        neg_q      <= 1'b0;
        in_frac_q  <= 1'b0;
        ovf_q      <= 1'b0;
        int_acc_q  <= '0;
        frac_acc_q <= '0;
      end
      if (emit_en)          out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      char_q <= in_i.char_code;
      last_q <= in_i.is_last;
    end
    if (sum_en) int_total_q <= int_total_d;
    if (emit_en) begin
      out_value_q <= fmt_value;
      out_ovf_q   <= fmt_ovf;
    end
  end

  assign in_i.ready     = in_ready;
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.value    = out_value_q;
  assign out_o.overflow = out_ovf_q;

endmodule

// ===== bench/radix_string_to_fixed_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfp_result_checker: result predictor and comparator for the string parser
// Follows radix writes and character transactions on the watched channels,
// parses each string into its signed Q32.32 value and overflow flag, and
// compares every result transaction with the oldest parsed string.
// ----------------------------------------------------------------------------
module rsfp_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rsfp_cfg_if  cfg_mon,
  rsfp_in_if   in_mon,
  rsfp_out_if  out_mon,
  output int   failures_o,
  output int   pending_o
);
  import rsfp_pkg::*;

  localparam int unsigned INT_W  = INT_BITS_DEF;
  localparam int unsigned FRAC_W = FRAC_BITS_DEF;

  localparam logic [63:0] INT_LIMIT = (64'd1 << INT_W) - 64'd1;
  localparam logic [63:0] INT_HALF  = 64'd1 << (INT_W - 1);
  localparam logic [63:0] Q_MAX     = {1'b0, {63{1'b1}}};
  localparam logic [63:0] Q_MIN     = {1'b1, 63'd0};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } parsed_number_t;

  parsed_number_t parsed_q[$];

  logic [RADIX_W-1:0] radix_q;
  logic [31:0]        int_part;
  logic [35:0]        frac_sum;
  logic [31:0]        weight;
  logic               minus_seen;
  logic               after_point;
  logic               at_start;
  logic               saturated;
  int                 mismatches = 0;
  int                 queued     = 0;

  assign failures_o = mismatches;
  assign pending_o  = queued;

  function automatic int unsigned base_of(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return 32'(RADIX_MIN);
    if (r > RADIX_MAX) return 32'(RADIX_MAX);
    return 32'(r);
  endfunction

  function automatic int digit_value(input logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    // keep the log short when something is badly broken
    if (mismatches < 100)
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_string();
    int_part    = '0;
    frac_sum    = '0;
    weight      = 32'((64'd1 << FRAC_W) / base_of(radix_q));
    minus_seen  = 1'b0;
    after_point = 1'b0;
    at_start    = 1'b1;
    saturated   = 1'b0;
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
    int unsigned    r;
    int             d;
    logic           consumed;
    logic [63:0]    acc;
    logic [63:0]    total;
    logic [63:0]    magnitude;
    logic [31:0]    frac_low;
    parsed_number_t num;
    consumed = 1'b0;
    if (at_start) begin
      // the weight is taken from the radix in force at the first character
      clear_string();
      at_start = 1'b0;
      if (c == CH_MINUS) begin
        minus_seen = 1'b1;
        consumed   = 1'b1;
      end
    end
    r = base_of(radix_q);
    if (!consumed) begin
      d = digit_value(c);
      if (!after_point && c == CH_POINT) begin
        after_point = 1'b1;
      end else if (d >= 0) begin
        if (!after_point) begin
          acc = 64'(int_part) * 64'(r) + 64'(d);
          if (acc > INT_LIMIT) begin
            acc       = INT_LIMIT;
            saturated = 1'b1;
          end
          int_part = acc[31:0];
        end else begin
          frac_sum = frac_sum + 36'(d) * 36'(weight);
          weight   = 32'(weight / r);
        end
      end
    end
    if (last) begin
      // fraction overflow carries into the integer part here
      total        = 64'(int_part) + 64'(frac_sum >> FRAC_W);
      frac_low     = frac_sum[FRAC_W-1:0];
      num.overflow = saturated;
      if (!minus_seen) begin
        if (saturated || total >= INT_HALF) begin
          num.overflow = 1'b1;
          num.value    = Q_MAX;
        end else begin
          num.value = {total[INT_W-1:0], frac_low};
        end
      end else begin
        if (saturated || total > INT_HALF || (total == INT_HALF && frac_low != '0)) begin
          num.overflow = 1'b1;
          num.value    = Q_MIN;
        end else begin
          magnitude = {total[INT_W-1:0], frac_low};
          num.value = -magnitude;
        end
      end
      parsed_q.push_back(num);
      clear_string();
    end
  endtask

  task automatic compare_result(input logic [63:0] value, input logic overflow);
    parsed_number_t num;
    if (parsed_q.size() == 0) begin
      report_mismatch("result with no string finished", value, '0);
    end else begin
      num = parsed_q.pop_front();
      if (value !== num.value) report_mismatch("value", value, num.value);
      if (overflow !== num.overflow) report_mismatch("overflow", 64'(overflow), 64'(num.overflow));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      clear_string();
      parsed_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) radix_q = cfg_mon.radix;
      if (in_mon.valid && in_mon.ready) parse_char(in_mon.char_code, in_mon.is_last);
      if (out_mon.valid && out_mon.ready) compare_result(out_mon.value, out_mon.overflow);
    end
    queued = parsed_q.size();
  end

endmodule

// ===== bench/radix_string_to_fixed_point_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_to_fixed_point_tb: stimulus and verdict for the string parser
// Feeds directed number strings, then random strings over a sweep of radix
// settings with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module radix_string_to_fixed_point_tb;
  import rsfp_pkg::*;

  localparam int          RESET_CYCLES = 9;
  localparam int          DRAIN_CYCLES = 48;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          NUM_PHASES   = 10;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef logic [CHAR_W-1:0] text_q_t[$];

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          quiet     = 1'b0;
  bit          stall_req = 1'b0;
  int unsigned cycles    = 0;
  int          failures;
  int          pending;

  rsfp_cfg_if cfg ();
  rsfp_in_if  chr ();
  rsfp_out_if res ();

  radix_string_to_fixed_point dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg),
    .in_i   (chr),
    .out_o  (res)
  );

  rsfp_result_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_mon    (cfg),
    .in_mon     (chr),
    .out_mon    (res),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        res.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res.ready = quiet || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while (!quiet && $urandom_range(99) < 24) begin
      chr.valid = 1'b0;
      @(negedge clk);
    end
    chr.valid     = 1'b1;
    chr.char_code = c;
    chr.is_last   = last;
    do @(posedge clk); while (!chr.ready);
    @(negedge clk);
    chr.valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_string(input text_q_t s, input bit finish);
    foreach (s[i]) send_char(s[i], finish && i == s.size() - 1);
  endtask

  // Let the parser go quiet before touching the radix
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.radix = r;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned r);
    int unsigned v;
    v = ($urandom_range(99) < 85) ? $urandom_range(r - 1) : $urandom_range(15);
    if (v < 10) return CH_0 + CHAR_W'(v);
    if ($urandom_range(1) == 0) return CH_UA + CHAR_W'(v - 10);
    return CH_LA + CHAR_W'(v - 10);
  endfunction

  function automatic text_q_t make_number(input int unsigned r);
    text_q_t     s;
    int unsigned n;
    s = {};
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6)) s.push_back(CHAR_W'($urandom_range(255)));
      return s;
    end
    if ($urandom_range(2) == 0) s.push_back(CH_MINUS);
    // mostly short parts, now and then long enough to saturate or zero the weight
    n = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
    repeat (n) s.push_back(digit_char(r));
    if ($urandom_range(3) != 0) begin
      s.push_back(CH_POINT);
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 36) : $urandom_range(0, 4);
      repeat (n) s.push_back(digit_char(r));
    end
    if ($urandom_range(4) == 0)
      s.insert($urandom_range(s.size()), CHAR_W'($urandom_range(255)));
    if ($urandom_range(9) == 0)
      s.insert($urandom_range(s.size()), ($urandom_range(1) != 0) ? CH_POINT : CH_MINUS);
    if (s.size() == 0) s.push_back(CHAR_W'($urandom_range(255)));
    return s;
  endfunction

  initial begin
    logic [RADIX_W-1:0] sweep [NUM_PHASES];
    text_q_t            s;
    int                 sent;
    sweep = '{5'd16, 5'd2, 5'd10, 5'd0, 5'd31, 5'd7, 5'd1, 5'd17, 5'd13, 5'd16};
    chr.valid     = 1'b0;
    chr.char_code = '0;
    chr.is_last   = 1'b0;
    cfg.valid     = 1'b0;
    cfg.radix     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // radix 10 from reset: lone minus, empty string, stray minus and point
    send_text("-");
    send_text("x");
    send_text("-1.5-.");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    // below the range acts as binary; fraction digits beyond the radix carry
    write_radix(5'd0);
    send_text("-1.1f");
    // above the range acts as hex; the most negative value without overflow
    write_radix(5'd31);
    send_text("-80000000");

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_radix(p == NUM_PHASES - 1 ? 5'($urandom_range(3, 15)) : sweep[p]);
      quiet = (p == 3);
      if (p == 5) stall_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        s = make_number(32'(sweep[p] < 2 ? 2 : (sweep[p] > 16 ? 16 : sweep[p])));
        send_string(s, 1'b1);
        sent += s.size();
      end
      // leave a string open so the next radix lands mid-string
      if (p % 2 == 1 && p != NUM_PHASES - 1) begin
        s = make_number(10);
        send_string(s, 1'b0);
      end
    end
    quiet = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
